/* sv/gain_droop_recovery_tracker_defines.svh */
// Assertion macros shared by the gain droop and recovery tracker RTL.
`ifndef GAIN_DROOP_RECOVERY_TRACKER_DEFINES_SVH
`define GAIN_DROOP_RECOVERY_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GDRT_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GDRT_ASSERT_NXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* sv/gdrt_pkg.sv */
// Types, constants and exponential tables of the gain droop and recovery tracker.
package gdrt_pkg;

    localparam int TIME_BITS   = 24;
    localparam int FRAC_BITS   = 24;
    localparam int RATE_BITS   = 24;
    localparam int Q_BITS      = 32;
    localparam int WHOLE_LIMIT = 16;
    localparam int WHOLE_BITS  = $clog2(WHOLE_LIMIT);
    localparam int X_BITS      = FRAC_BITS + WHOLE_BITS;
    localparam int OP_W        = Q_BITS + 1;
    localparam int PROD_W      = 2 * OP_W;
    localparam int GAIN_W      = FRAC_BITS + 1;
    localparam int CNT_W       = $clog2(FRAC_BITS + 1);

    localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(932068);
    localparam logic [GAIN_W-1:0]    ONE_GAIN   = GAIN_W'(1) << FRAC_BITS;
    localparam logic [OP_W-1:0]      ONE_Q32    = OP_W'(1) << Q_BITS;

    typedef logic [OP_W-1:0] q32_t;
    typedef q32_t whole_tab_t [WHOLE_LIMIT];
    typedef q32_t bit_tab_t [FRAC_BITS+1];

    typedef enum logic [1:0] {
        REQ_PULSE = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_FILL  = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XMUL,
        ST_XLOAD,
        ST_EBIT,
        ST_DMUL,
        ST_DDONE,
        ST_PFIN,
        ST_RES
    } state_t;

    typedef enum logic [1:0] {
        RND_NONE,
        RND_HALF_Q32,
        RND_HALF_FRAC
    } rnd_t;

    typedef struct packed {
        logic en;
        rnd_t rnd;
        q32_t a;
        q32_t b;
    } mul_req_t;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [TIME_BITS-1:0] event_time;
        logic [FRAC_BITS-1:0] drop_fraction;
    } item_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_value;
        logic              order_error;
    } result_t;

    // exp(-2^-s) in Q0.32 from the alternating series summed in Q0.60.
    function automatic q32_t exp_neg_pow2(input int unsigned s);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] v;
        term = 64'd1 << 60;
        pos  = term;
        neg  = 64'd0;
        for (int unsigned n = 1; n < 40; n++)
        begin
            term = (term >> s) / 64'(n);
            if (n[0])
            begin
                neg = neg + term;
            end
            else
            begin
                pos = pos + term;
            end
        end
        v = (pos - neg + (64'd1 << 27)) >> 28;
        if (v >= (64'd1 << Q_BITS))
        begin
            v = (64'd1 << Q_BITS) - 64'd1;
        end
        return v[OP_W-1:0];
    endfunction

    function automatic whole_tab_t build_whole();
        whole_tab_t  tab;
        logic [63:0] p;
        tab[0] = ONE_Q32;
        tab[1] = exp_neg_pow2(0);
        for (int k = 2; k < WHOLE_LIMIT; k++)
        begin
            p      = 64'(tab[k-1]) * 64'(tab[1]) + (64'd1 << 31);
            tab[k] = OP_W'(p >> Q_BITS);
        end
        return tab;
    endfunction

    function automatic bit_tab_t build_bits();
        bit_tab_t tab;
        tab[0] = ONE_Q32;
        for (int k = 1; k <= FRAC_BITS; k++)
        begin
            tab[k] = exp_neg_pow2(k);
        end
        return tab;
    endfunction

    localparam whole_tab_t WHOLE_TAB = build_whole();
    localparam bit_tab_t   BIT_TAB   = build_bits();

endpackage

/* sv/gdrt_mul.sv */
// Shared multiply unit with rounding offset and a registered product.
module gdrt_mul
(
    input  logic                          clk,
    input  gdrt_pkg::mul_req_t            req,
    output logic [gdrt_pkg::PROD_W-1:0]   prod
);

    logic [gdrt_pkg::PROD_W-1:0] prod_reg;
    logic [gdrt_pkg::PROD_W-1:0] prod_next;
    logic [gdrt_pkg::PROD_W-1:0] rnd_const;

    always_comb
    begin
        case (req.rnd)
            gdrt_pkg::RND_HALF_Q32:  rnd_const = gdrt_pkg::PROD_W'(1) << (gdrt_pkg::Q_BITS - 1);
            gdrt_pkg::RND_HALF_FRAC: rnd_const = gdrt_pkg::PROD_W'(1) << (gdrt_pkg::FRAC_BITS - 1);
            default:                 rnd_const = '0;
        endcase
    end

    assign prod_next = gdrt_pkg::PROD_W'(req.a) * gdrt_pkg::PROD_W'(req.b) + rnd_const;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

/* sv/gain_droop_recovery_tracker.sv */
// Top level of the gain droop and recovery tracker.
//
// Requests arrive on the item channel (valid and stall) and carry a type, a time stamp
// and a drop fraction. A pulse lets the stored deficit decay since the last pulse and
// then applies its drop; a query returns the gain at its time on the result channel;
// a fill start returns the tracker to a gain of exactly one.
// The recovery rate is written through the cfg channel while the block is idle.
// One request is worked on at a time, and item_stall is high until it is finished.
// A fill start, an ignored type or the first pulse after a fill causes no stall.
// An out-of-order request or a query before any pulse goes from idle straight to the
// result state, so its result is loaded without the multiplier.
// Any other request runs through one shared multiplier: the exponent, the table load,
// one step for each of the 24 fraction bits of the exponent, the deficit product and,
// for a pulse, the drop product. The bit steps are skipped when the exponent is 16 or
// more, and item_stall stays high until the request is finished. The result sits in an
// output register and is held while result_stall is high; a request whose result is
// ready while that register is still full keeps item_stall high until the held result
// is taken. Reset clears the deficit, the last pulse time and the pulse flag and loads
// the default recovery rate.
`include "gain_droop_recovery_tracker_defines.svh"

module gain_droop_recovery_tracker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  gdrt_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output gdrt_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gdrt_pkg::RATE_BITS-1:0]    cfg_data
);

    localparam int TB = gdrt_pkg::TIME_BITS;
    localparam int FB = gdrt_pkg::FRAC_BITS;

    gdrt_pkg::state_t                 state_reg,     state_next;
    logic [gdrt_pkg::RATE_BITS-1:0]   rate_reg;
    logic [FB-1:0]                    deficit_reg,   deficit_next;
    logic [TB-1:0]                    last_time_reg, last_time_next;
    logic                             seen_reg,      seen_next;
    logic                             res_valid_reg, res_valid_next;
    gdrt_pkg::result_t                res_reg,       res_next;

    logic                             query_reg,     query_next;
    logic [FB-1:0]                    drop_reg,      drop_next;
    logic [TB-1:0]                    time_reg,      time_next;
    logic [TB-1:0]                    dt_reg,        dt_next;
    logic [FB-1:0]                    frac_reg,      frac_next;
    logic                             zero_reg,      zero_next;
    logic [gdrt_pkg::CNT_W-1:0]       cnt_reg,       cnt_next;
    logic [FB-1:0]                    de_reg,        de_next;
    logic [gdrt_pkg::GAIN_W-1:0]      pend_gain_reg, pend_gain_next;
    logic                             pend_err_reg,  pend_err_next;

    gdrt_pkg::mul_req_t               mul_req;
    logic [gdrt_pkg::PROD_W-1:0]      prod;

    logic                             accept;
    logic                             t_early;
    logic                             big_x;
    logic                             res_free;
    logic [gdrt_pkg::OP_W-1:0]        r_val;
    logic [FB-1:0]                    de_val;
    logic [FB-1:0]                    dd_term;
    logic [FB+1:0]                    nd_sum;

    gdrt_mul u_mul
    (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    assign item_stall   = (state_reg != gdrt_pkg::ST_IDLE);
    assign cfg_ready    = (state_reg == gdrt_pkg::ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign t_early      = (item.event_time < last_time_reg);
    assign big_x        = |prod[gdrt_pkg::PROD_W-1:gdrt_pkg::X_BITS];
    assign res_free     = !res_valid_reg || !result_stall;
    assign r_val        = prod[gdrt_pkg::Q_BITS +: gdrt_pkg::OP_W];
    assign de_val       = prod[gdrt_pkg::Q_BITS +: FB];
    assign dd_term      = prod[FB +: FB];
    assign nd_sum       = {2'b00, de_reg} + {2'b00, drop_reg} - {2'b00, dd_term};
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gdrt_pkg::ST_IDLE:
            begin
                if (accept && (item.req_type == gdrt_pkg::REQ_PULSE ||
                               item.req_type == gdrt_pkg::REQ_QUERY))
                begin
                    if (t_early || (!seen_reg && item.req_type == gdrt_pkg::REQ_QUERY))
                    begin
                        state_next = gdrt_pkg::ST_RES;
                    end
                    else if (seen_reg)
                    begin
                        state_next = gdrt_pkg::ST_XMUL;
                    end
                end
            end
            gdrt_pkg::ST_XMUL:  state_next = gdrt_pkg::ST_XLOAD;
            gdrt_pkg::ST_XLOAD: state_next = big_x ? gdrt_pkg::ST_DMUL : gdrt_pkg::ST_EBIT;
            gdrt_pkg::ST_EBIT:
            begin
                if (cnt_reg == gdrt_pkg::CNT_W'(FB))
                begin
                    state_next = gdrt_pkg::ST_DMUL;
                end
            end
            gdrt_pkg::ST_DMUL:  state_next = gdrt_pkg::ST_DDONE;
            gdrt_pkg::ST_DDONE: state_next = query_reg ? gdrt_pkg::ST_RES : gdrt_pkg::ST_PFIN;
            gdrt_pkg::ST_PFIN:  state_next = gdrt_pkg::ST_IDLE;
            gdrt_pkg::ST_RES:
            begin
                if (res_free)
                begin
                    state_next = gdrt_pkg::ST_IDLE;
                end
            end
            default:            state_next = gdrt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        deficit_next   = deficit_reg;
        last_time_next = last_time_reg;
        seen_next      = seen_reg;
        query_next     = query_reg;
        drop_next      = drop_reg;
        time_next      = time_reg;
        dt_next        = dt_reg;
        frac_next      = frac_reg;
        zero_next      = zero_reg;
        cnt_next       = cnt_reg;
        de_next        = de_reg;
        pend_gain_next = pend_gain_reg;
        pend_err_next  = pend_err_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && result_stall;
        mul_req.en     = 1'b0;
        mul_req.rnd    = gdrt_pkg::RND_NONE;
        mul_req.a      = '0;
        mul_req.b      = '0;

        case (state_reg)
            gdrt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    query_next = (item.req_type == gdrt_pkg::REQ_QUERY);
                    drop_next  = item.drop_fraction;
                    time_next  = item.event_time;
                    dt_next    = item.event_time - last_time_reg;
                    case (item.req_type)
                        gdrt_pkg::REQ_FILL:
                        begin
                            deficit_next   = '0;
                            last_time_next = '0;
                            seen_next      = 1'b0;
                        end
                        gdrt_pkg::REQ_PULSE, gdrt_pkg::REQ_QUERY:
                        begin
                            if (t_early)
                            begin
                                pend_gain_next = '0;
                                pend_err_next  = 1'b1;
                            end
                            else if (!seen_reg)
                            begin
                                pend_gain_next = gdrt_pkg::ONE_GAIN;
                                pend_err_next  = 1'b0;
                                if (item.req_type == gdrt_pkg::REQ_PULSE)
                                begin
                                    deficit_next   = item.drop_fraction;
                                    last_time_next = item.event_time;
                                    seen_next      = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            gdrt_pkg::ST_XMUL:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = gdrt_pkg::OP_W'(dt_reg);
                mul_req.b  = gdrt_pkg::OP_W'(rate_reg);
            end
            gdrt_pkg::ST_XLOAD:
            begin
                zero_next  = big_x;
                frac_next  = prod[FB-1:0];
                cnt_next   = gdrt_pkg::CNT_W'(1);
                mul_req.en = 1'b1;
                mul_req.a  = gdrt_pkg::WHOLE_TAB[prod[gdrt_pkg::X_BITS-1:FB]];
                mul_req.b  = gdrt_pkg::ONE_Q32;
            end
            gdrt_pkg::ST_EBIT:
            begin
                frac_next = frac_reg << 1;
                cnt_next  = cnt_reg + gdrt_pkg::CNT_W'(1);
                if (frac_reg[FB-1])
                begin
                    mul_req.en  = 1'b1;
                    mul_req.rnd = gdrt_pkg::RND_HALF_Q32;
                    mul_req.a   = r_val;
                    mul_req.b   = gdrt_pkg::BIT_TAB[cnt_reg];
                end
            end
            gdrt_pkg::ST_DMUL:
            begin
                mul_req.en  = 1'b1;
                mul_req.rnd = gdrt_pkg::RND_HALF_Q32;
                mul_req.a   = gdrt_pkg::OP_W'(deficit_reg);
                mul_req.b   = zero_reg ? '0 : r_val;
            end
            gdrt_pkg::ST_DDONE:
            begin
                de_next = de_val;
                if (query_reg)
                begin
                    pend_gain_next = gdrt_pkg::ONE_GAIN - gdrt_pkg::GAIN_W'(de_val);
                    pend_err_next  = 1'b0;
                end
                else
                begin
                    mul_req.en  = 1'b1;
                    mul_req.rnd = gdrt_pkg::RND_HALF_FRAC;
                    mul_req.a   = gdrt_pkg::OP_W'(de_val);
                    mul_req.b   = gdrt_pkg::OP_W'(drop_reg);
                end
            end
            gdrt_pkg::ST_PFIN:
            begin
                deficit_next   = (nd_sum[FB+1:FB] != 2'b00) ? '1 : nd_sum[FB-1:0];
                last_time_next = time_reg;
                seen_next      = 1'b1;
            end
            gdrt_pkg::ST_RES:
            begin
                if (res_free)
                begin
                    res_next.gain_value  = pend_gain_reg;
                    res_next.order_error = pend_err_reg;
                    res_valid_next       = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gdrt_pkg::ST_IDLE;
            rate_reg      <= gdrt_pkg::RATE_RESET;
            deficit_reg   <= '0;
            last_time_reg <= '0;
            seen_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            deficit_reg   <= deficit_next;
            last_time_reg <= last_time_next;
            seen_reg      <= seen_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                rate_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg     <= query_next;
        drop_reg      <= drop_next;
        time_reg      <= time_next;
        dt_reg        <= dt_next;
        frac_reg      <= frac_next;
        zero_reg      <= zero_next;
        cnt_reg       <= cnt_next;
        de_reg        <= de_next;
        pend_gain_reg <= pend_gain_next;
        pend_err_reg  <= pend_err_next;
        res_reg       <= res_next;
    end

    `GDRT_ASSERT_NXT(a_fill_clears, accept && item.req_type == gdrt_pkg::REQ_FILL, deficit_reg == '0 && last_time_reg == '0 && !seen_reg, "A fill start did not clear the tracker state.")
    `GDRT_ASSERT_IMP(a_gain_max, result_valid, result.gain_value <= gdrt_pkg::ONE_GAIN, "A result gain exceeds one.")
    `GDRT_ASSERT_IMP(a_error_gain, result_valid && result.order_error, result.gain_value == '0, "An order error result carries a nonzero gain.")
    `GDRT_ASSERT_IMP(a_mul_busy, mul_req.en, state_reg != gdrt_pkg::ST_IDLE && state_reg != gdrt_pkg::ST_RES, "The multiplier was started outside a computation.")

endmodule

/* sim/tb_gain_droop_recovery_tracker.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the gain droop and recovery tracker, with its own gain predictor.
module tb_gain_droop_recovery_tracker;

    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 285;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 64;
    localparam int IDLE_LIMIT    = 4000;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [63:0] TIME_TOP  = (64'd1 << gdrt_pkg::TIME_BITS) - 64'd1;
    localparam logic [63:0] FRAC_TOP  = (64'd1 << gdrt_pkg::FRAC_BITS) - 64'd1;
    localparam logic [63:0] X_LIMIT   = 64'(gdrt_pkg::WHOLE_LIMIT) << gdrt_pkg::FRAC_BITS;
    localparam logic [63:0] UNITY_Q32 = 64'd1 << 32;

    typedef struct {
        gdrt_pkg::item_t   it;
        bit                typed;
        gdrt_pkg::result_t want;
    } script_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           item_valid;
    logic                           item_stall;
    gdrt_pkg::item_t                item;
    logic                           result_valid;
    logic                           result_stall;
    gdrt_pkg::result_t              result;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [gdrt_pkg::RATE_BITS-1:0] cfg_data;

    logic [63:0] whole_exp [gdrt_pkg::WHOLE_LIMIT];
    logic [63:0] frac_exp [gdrt_pkg::FRAC_BITS+1];
    logic [63:0] model_rate;
    logic [63:0] model_deficit;
    logic [63:0] model_last;
    bit          model_seen;

    gdrt_pkg::result_t expected_gains [$];
    script_row_t       script [$];
    int unsigned       fault_count;
    int unsigned       idle_cycles;
    bit                hold_results;

    gain_droop_recovery_tracker dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] series_exp(input int unsigned shift);
        logic [63:0] term;
        logic [63:0] sum_pos;
        logic [63:0] sum_neg;
        logic [63:0] v;
        term    = 64'd1 << 60;
        sum_pos = term;
        sum_neg = 64'd0;
        for (int unsigned n = 1; n < 40 && term != 64'd0; n++)
        begin
            term = (term >> shift) / 64'(n);
            if (n % 2 == 1)
            begin
                sum_neg = sum_neg + term;
            end
            else
            begin
                sum_pos = sum_pos + term;
            end
        end
        v = (sum_pos - sum_neg + (64'd1 << 27)) >> 28;
        return (v >= UNITY_Q32) ? UNITY_Q32 - 64'd1 : v;
    endfunction

    function automatic logic [63:0] decay_q32(input logic [63:0] dt);
        logic [63:0] x;
        logic [63:0] r;
        if (model_rate != 64'd0 && dt > (X_LIMIT - 64'd1) / model_rate)
        begin
            return 64'd0;
        end
        x = dt * model_rate;
        r = whole_exp[x[gdrt_pkg::FRAC_BITS +: gdrt_pkg::WHOLE_BITS]];
        for (int j = 1; j <= gdrt_pkg::FRAC_BITS; j++)
        begin
            if (x[gdrt_pkg::FRAC_BITS-j])
            begin
                r = (r * frac_exp[j] + (64'd1 << 31)) >> 32;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] decayed_deficit(input logic [63:0] t);
        logic [63:0] e;
        e = decay_q32((t - model_last) & TIME_TOP);
        return (model_deficit * e + (64'd1 << 31)) >> 32;
    endfunction

    function automatic bit track_request(input gdrt_pkg::item_t it,
                                         output gdrt_pkg::result_t res);
        logic [63:0] t;
        logic [63:0] d;
        logic [63:0] de;
        logic [63:0] nd;
        t   = 64'(it.event_time);
        d   = 64'(it.drop_fraction);
        res = '0;
        if (it.req_type == gdrt_pkg::REQ_FILL)
        begin
            model_deficit = 64'd0;
            model_last    = 64'd0;
            model_seen    = 1'b0;
            return 1'b0;
        end
        if (it.req_type == gdrt_pkg::REQ_NONE)
        begin
            return 1'b0;
        end
        if (t < model_last)
        begin
            res.order_error = 1'b1;
            return 1'b1;
        end
        if (it.req_type == gdrt_pkg::REQ_QUERY)
        begin
            res.gain_value = model_seen
                ? gdrt_pkg::GAIN_W'((64'd1 << gdrt_pkg::FRAC_BITS) - decayed_deficit(t))
                : gdrt_pkg::ONE_GAIN;
            return 1'b1;
        end
        de = model_seen ? decayed_deficit(t) : 64'd0;
        nd = de + d - ((de * d + (64'd1 << (gdrt_pkg::FRAC_BITS - 1))) >> gdrt_pkg::FRAC_BITS);
        model_deficit = (nd > FRAC_TOP) ? FRAC_TOP : nd;
        model_last    = t;
        model_seen    = 1'b1;
        return 1'b0;
    endfunction

    function automatic gdrt_pkg::item_t make_item(input gdrt_pkg::req_type_t kind,
                                                  input logic [63:0] t,
                                                  input logic [63:0] d);
        gdrt_pkg::item_t it;
        it.req_type      = kind;
        it.event_time    = t[gdrt_pkg::TIME_BITS-1:0];
        it.drop_fraction = d[gdrt_pkg::FRAC_BITS-1:0];
        return it;
    endfunction

    function automatic logic [63:0] pick_drop();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            return 64'($urandom_range(0, 32'(FRAC_TOP)));
        end
        else if (pick < 80)
        begin
            return 64'($urandom_range(0, 4095));
        end
        else if (pick < 90)
        begin
            return FRAC_TOP - 64'($urandom_range(0, 4095));
        end
        return ($urandom_range(0, 1) == 0) ? 64'd0 : FRAC_TOP;
    endfunction

    function automatic logic [63:0] next_time(input logic [63:0] now);
        logic [63:0] span;
        logic [63:0] room;
        logic [63:0] dt;
        int unsigned pick;
        room = TIME_TOP - now;
        span = (model_rate == 64'd0) ? 64'd4000 : X_LIMIT / model_rate + 64'd1;
        if (span > 64'd1000000)
        begin
            span = 64'd1000000;
        end
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            dt = 64'd0;
        end
        else if (pick < 65)
        begin
            dt = 64'($urandom_range(1, 32'(span / 8 + 1)));
        end
        else if (pick < 92)
        begin
            dt = 64'($urandom_range(1, 32'(span + span / 4)));
        end
        else
        begin
            dt = 64'($urandom_range(0, 32'(room)));
        end
        if (dt > room)
        begin
            dt = room;
        end
        return now + dt;
    endfunction

    task automatic add_row(input gdrt_pkg::req_type_t kind, input logic [63:0] t,
                           input logic [63:0] d, input bit typed,
                           input logic [gdrt_pkg::GAIN_W-1:0] gain, input bit err);
        script_row_t row;
        row.it                = make_item(kind, t, d);
        row.typed             = typed;
        row.want.gain_value   = gain;
        row.want.order_error  = err;
        script = {script, row};
    endtask

    task automatic send_request(input gdrt_pkg::item_t it, input bit typed,
                                input gdrt_pkg::result_t want);
        gdrt_pkg::result_t predicted;
        bit                has_result;
        item       <= it;
        item_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        has_result = track_request(it, predicted);
        if (typed)
        begin
            expected_gains = {expected_gains, want};
        end
        else if (has_result)
        begin
            expected_gains = {expected_gains, predicted};
        end
    endtask

    task automatic idle_gap(input bit burst);
        int unsigned pick;
        int unsigned gap;
        if (burst)
        begin
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            gap = 0;
        end
        else if (pick < 88)
        begin
            gap = $urandom_range(1, 3);
        end
        else if (pick < 97)
        begin
            gap = $urandom_range(4, 15);
        end
        else
        begin
            gap = $urandom_range(30, 90);
        end
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (expected_gains.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_recovery_rate(input logic [gdrt_pkg::RATE_BITS-1:0] rate);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_data  <= rate;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        model_rate = 64'(rate);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stalls, with a long hold-off whenever the sender asks for one.
    initial
    begin
        int unsigned busy_left;
        int unsigned free_left;
        int unsigned pick;
        busy_left    = 0;
        free_left    = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                busy_left    = HOLD_CYCLES;
                hold_results = 1'b0;
            end
            else if (busy_left == 0 && free_left == 0)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 25)
                begin
                    free_left = $urandom_range(20, 120);
                end
                else if (pick < 85)
                begin
                    busy_left = $urandom_range(1, 3);
                    free_left = $urandom_range(0, 4);
                end
                else if (pick < 97)
                begin
                    busy_left = $urandom_range(4, 15);
                    free_left = $urandom_range(0, 4);
                end
                else
                begin
                    busy_left = $urandom_range(30, 80);
                end
            end
            if (busy_left > 0)
            begin
                result_stall <= 1'b1;
                busy_left--;
            end
            else
            begin
                result_stall <= 1'b0;
                if (free_left > 0)
                begin
                    free_left--;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        gdrt_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_gains.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                begin
                    $display("%0t: result with no request pending: gain %0d order_error %0b",
                             $time, result.gain_value, result.order_error);
                end
            end
            else
            begin
                want = expected_gains.pop_front();
                if (result.gain_value !== want.gain_value
                    || result.order_error !== want.order_error)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: expected gain %0d error %0b, got gain %0d error %0b",
                                 $time, want.gain_value, want.order_error,
                                 result.gain_value, result.order_error);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("gain_droop_recovery_tracker: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned         sent;
        int unsigned         len;
        logic [63:0]         now;
        logic [63:0]         t;
        bit                  burst;
        gdrt_pkg::req_type_t kind;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        hold_results = 1'b0;
        fault_count  = 0;
        idle_cycles  = 0;

        whole_exp[0] = UNITY_Q32;
        whole_exp[1] = series_exp(0);
        for (int k = 2; k < gdrt_pkg::WHOLE_LIMIT; k++)
        begin
            whole_exp[k] = (whole_exp[k-1] * whole_exp[1] + (64'd1 << 31)) >> 32;
        end
        frac_exp[0] = UNITY_Q32;
        for (int k = 1; k <= gdrt_pkg::FRAC_BITS; k++)
        begin
            frac_exp[k] = series_exp(k);
        end
        model_rate    = 64'(gdrt_pkg::RATE_RESET);
        model_deficit = 64'd0;
        model_last    = 64'd0;
        model_seen    = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        add_row(gdrt_pkg::REQ_QUERY, 0,        0,          1'b1, gdrt_pkg::ONE_GAIN, 1'b0);
        add_row(gdrt_pkg::REQ_QUERY, TIME_TOP, 0,          1'b1, gdrt_pkg::ONE_GAIN, 1'b0);
        add_row(gdrt_pkg::REQ_PULSE, 100,      0,          1'b0, '0,                 1'b0);
        add_row(gdrt_pkg::REQ_QUERY, 100,      0,          1'b1, gdrt_pkg::ONE_GAIN, 1'b0);
        add_row(gdrt_pkg::REQ_PULSE, 100,      FRAC_TOP,   1'b0, '0,                 1'b0);
        add_row(gdrt_pkg::REQ_QUERY, 100,      0,          1'b1, gdrt_pkg::GAIN_W'(1), 1'b0);
        add_row(gdrt_pkg::REQ_QUERY, 99,       0,          1'b1, '0,                 1'b1);
        add_row(gdrt_pkg::REQ_PULSE, 50,       123,        1'b1, '0,                 1'b1);
        add_row(gdrt_pkg::REQ_NONE,  0,        FRAC_TOP,   1'b0, '0,                 1'b0);
        add_row(gdrt_pkg::REQ_PULSE, 100,      FRAC_TOP,   1'b0, '0,                 1'b0);
        add_row(gdrt_pkg::REQ_QUERY, 400,      0,          1'b1, gdrt_pkg::ONE_GAIN, 1'b0);
        add_row(gdrt_pkg::REQ_QUERY, 101,      0,          1'b0, '0,                 1'b0);
        add_row(gdrt_pkg::REQ_QUERY, 110,      0,          1'b0, '0,                 1'b0);
        add_row(gdrt_pkg::REQ_PULSE, 110,      64'h800000, 1'b0, '0,                 1'b0);
        add_row(gdrt_pkg::REQ_QUERY, 110,      0,          1'b0, '0,                 1'b0);
        add_row(gdrt_pkg::REQ_FILL,  55,       64'h5A5A5A, 1'b0, '0,                 1'b0);
        add_row(gdrt_pkg::REQ_QUERY, 0,        0,          1'b1, gdrt_pkg::ONE_GAIN, 1'b0);
        add_row(gdrt_pkg::REQ_PULSE, TIME_TOP, FRAC_TOP,   1'b0, '0,                 1'b0);
        add_row(gdrt_pkg::REQ_QUERY, TIME_TOP, 0,          1'b1, gdrt_pkg::GAIN_W'(1), 1'b0);
        add_row(gdrt_pkg::REQ_QUERY, TIME_TOP - 1, 0,      1'b1, '0,                 1'b1);
        add_row(gdrt_pkg::REQ_PULSE, TIME_TOP, 0,          1'b0, '0,                 1'b0);
        add_row(gdrt_pkg::REQ_FILL,  TIME_TOP, FRAC_TOP,   1'b0, '0,                 1'b0);
        add_row(gdrt_pkg::REQ_NONE,  TIME_TOP, FRAC_TOP,   1'b0, '0,                 1'b0);
        add_row(gdrt_pkg::REQ_PULSE, 0,        1,          1'b0, '0,                 1'b0);
        add_row(gdrt_pkg::REQ_QUERY, 0,        0,          1'b0, '0,                 1'b0);
        foreach (script[i])
        begin
            send_request(script[i].it, script[i].typed, script[i].want);
            idle_gap(1'b0);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: set_recovery_rate('1);
                1: set_recovery_rate('0);
                2: set_recovery_rate(gdrt_pkg::RATE_BITS'(1));
                3: set_recovery_rate(gdrt_pkg::RATE_BITS'($urandom_range(100000, 4000000)));
                4: set_recovery_rate(gdrt_pkg::RATE_RESET);
                default: set_recovery_rate(gdrt_pkg::RATE_BITS'(
                             $urandom_range(0, (1 << gdrt_pkg::RATE_BITS) - 1)));
            endcase

            // The receiver holds off while requests keep coming, so the block backs up.
            if (ph == 1 || ph == 4)
            begin
                hold_results = 1'b1;
                now = 64'($urandom_range(0, 1 << 20));
                send_request(make_item(gdrt_pkg::REQ_FILL, now, 0), 1'b0, '0);
                send_request(make_item(gdrt_pkg::REQ_PULSE, now, pick_drop()), 1'b0, '0);
                repeat (40)
                begin
                    now  = next_time(now);
                    kind = ($urandom_range(0, 3) == 0) ? gdrt_pkg::REQ_PULSE
                                                       : gdrt_pkg::REQ_QUERY;
                    send_request(make_item(kind, now, pick_drop()), 1'b0, '0);
                end
                wait_drained();
            end

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                burst = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 99) < 85)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        now = TIME_TOP - 64'($urandom_range(0, 2000));
                    end
                    else
                    begin
                        now = 64'($urandom_range(0, 32'(TIME_TOP)));
                    end
                    send_request(make_item(gdrt_pkg::REQ_FILL,
                                           64'($urandom_range(0, 32'(TIME_TOP))),
                                           pick_drop()), 1'b0, '0);
                    sent++;
                    len = $urandom_range(4, 24);
                    repeat (len)
                    begin
                        idle_gap(burst);
                        if ($urandom_range(0, 99) < 5 && model_last > 0)
                        begin
                            t = 64'($urandom_range(0, 32'(model_last - 1)));
                        end
                        else
                        begin
                            now = next_time(now);
                            t   = now;
                        end
                        kind = ($urandom_range(0, 1) == 0) ? gdrt_pkg::REQ_PULSE
                                                           : gdrt_pkg::REQ_QUERY;
                        send_request(make_item(kind, t, pick_drop()), 1'b0, '0);
                        sent++;
                    end
                end
                else
                begin
                    kind = gdrt_pkg::req_type_t'($urandom_range(0, 3));
                    send_request(make_item(kind, 64'($urandom_range(0, 32'(TIME_TOP))),
                                           pick_drop()), 1'b0, '0);
                    if (kind != gdrt_pkg::REQ_NONE)
                    begin
                        sent++;
                    end
                end
                idle_gap(burst);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0 && expected_gains.size() == 0)
        begin
            $display("gain_droop_recovery_tracker: match");
        end
        else
        begin
            $display("gain_droop_recovery_tracker: mismatch");
        end
        $finish;
    end

endmodule

/* gain_droop_recovery_tracker.f */
+incdir+sv
sv/gdrt_pkg.sv
sv/gdrt_mul.sv
sv/gain_droop_recovery_tracker.sv
sim/tb_gain_droop_recovery_tracker.sv
